// ===== rtl/core/psw_pkg.sv =====
// shared types, constants and packing helpers for the progress stall watchdog
package psw_pkg;

    localparam int FRAME_BITS = 32;
    // frame fields arrive 32 bits wide on the stream
    localparam int FRAME_W = (FRAME_BITS < 32) ? FRAME_BITS : 32;

    localparam int IN_TDATA_W  = 272;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TOL_W       = 10;

    localparam logic [TOL_W-1:0] MIN_TOLERANCE = TOL_W'(6);
    localparam logic [TOL_W-1:0] TOLERANCE_PAD = TOL_W'(2);

    localparam logic [15:0] STALL_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] CHURN_THRESH_RST  = 16'd8;
    localparam logic [15:0] COOLDOWN_RST      = 16'd5000;
    localparam logic [7:0]  DELAY_RST         = 8'd2;
    localparam logic [7:0]  PREDICT_RST       = 8'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STALL_TIMEOUT = 3'd0,
        CFG_CHURN_THRESH  = 3'd1,
        CFG_COOLDOWN      = 3'd2,
        CFG_DELAY         = 3'd3,
        CFG_PREDICT       = 3'd4
    } cfg_idx_t;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic [15:0] stall_timeout_ms;
        logic [15:0] churn_threshold;
        logic [15:0] cooldown_ms;
        logic [7:0]  delay_frames;
        logic [7:0]  prediction_frames;
    } cfg_t;

    typedef struct packed {
        logic        session_ok;
        logic        resync_idle;
        logic [7:0]  remote_peers;
        logic        is_host;
        logic [31:0] epoch;
        frame_t      local_frame;
        frame_t      confirmed_frame;
        frame_t      remote_current_frame;
        frame_t      remote_confirmed_frame;
        logic [31:0] stop_count;
        logic [31:0] rollback_count;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        request_resync;
        logic [31:0] stalled_ms;
        logic [31:0] stop_delta;
        logic [31:0] rollback_delta;
    } res_t;

    typedef struct packed {
        logic fire;
        logic cool_armed;
        logic baseline_valid;
    } core_status_t;

    function automatic in_item_t unpack_in(input logic [IN_TDATA_W-1:0] d);
        in_item_t it;
        logic [31:0] lf, cf, rcur, rconf;
        lf                        = d[74:43];
        cf                        = d[106:75];
        rcur                      = d[138:107];
        rconf                     = d[170:139];
        it.session_ok             = d[0];
        it.resync_idle            = d[1];
        it.remote_peers           = d[9:2];
        it.is_host                = d[10];
        it.epoch                  = d[42:11];
        it.local_frame            = frame_t'(lf);
        it.confirmed_frame        = frame_t'(cf);
        it.remote_current_frame   = frame_t'(rcur);
        it.remote_confirmed_frame = frame_t'(rconf);
        it.stop_count             = d[202:171];
        it.rollback_count         = d[234:203];
        it.now_ms                 = d[266:235];
        return it;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_out(input res_t r);
        return {7'd0, r.rollback_delta, r.stop_delta, r.stalled_ms, r.request_resync};
    endfunction

endpackage

// ===== rtl/core/progress_stall_watchdog.sv =====
// top level of the progress stall watchdog: stream stages, config bank and core
// One status snapshot in, one result out, at a sustained rate of one transaction
// per clock while the output side does not stall. A snapshot is captured in an
// input register, evaluated combinationally against the baseline state and
// written to an output register, which presents the result; the baseline update
// in psw_core, made with each step, sets the rate. Stalls on the output side
// hold the output register and any snapshot in the input register, and
// deassert s_axis_tready once the input register is full. Configuration writes
// take effect at once and should be made only while no transaction is in flight.
module progress_stall_watchdog (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // session_ok, resync_idle, remote_peers[7:0], is_host, epoch[31:0],
    // local_frame[31:0], confirmed_frame[31:0], remote_current_frame[31:0],
    // remote_confirmed_frame[31:0], stop_count[31:0], rollback_count[31:0],
    // now_ms[31:0], zero pad
    input  logic [psw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // request_resync, stalled_ms[31:0], stop_delta[31:0], rollback_delta[31:0],
    // zero pad
    output logic [psw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [psw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [psw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                            in_vld_reg, in_vld_next;
    logic [psw_pkg::IN_TDATA_W-1:0]  in_data_reg;
    logic                            out_vld_reg, out_vld_next;
    logic [psw_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            step, in_take;
    psw_pkg::cfg_t                   cfg;
    psw_pkg::in_item_t               item;
    psw_pkg::res_t                   res;
    psw_pkg::core_status_t           status;

    psw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign item = psw_pkg::unpack_in(in_data_reg);

    psw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .res    (res),
        .status (status)
    );

    always_comb
    begin
        step          = in_vld_reg && (!out_vld_reg || m_axis_tready);
        s_axis_tready = !in_vld_reg || step;
        in_take       = s_axis_tvalid && s_axis_tready;
        in_vld_next   = in_take || (in_vld_reg && !step);
        out_vld_next  = step || (out_vld_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= s_axis_tdata;
        if (step)
            out_data_reg <= psw_pkg::pack_out(res);
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a request always re-arms the baseline and the cooldown
    a_fire_arms: assert property (@(posedge clk) disable iff (!rst_n)
        status.fire |=> (status.cool_armed && status.baseline_valid))
        else $error("request did not arm cooldown and baseline");

    // numbers are reported only alongside a request
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[96:1] == 96'd0))
        else $error("report fields set without a request");

    // a held snapshot is not lost while the output side stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !step) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("pending snapshot dropped");
`endif

endmodule

// ===== rtl/core/psw_cfg_regs.sv =====
// configuration register bank of the progress stall watchdog
module psw_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psw_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [psw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output psw_pkg::cfg_t                  cfg
);

    psw_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stall_timeout_ms  <= psw_pkg::STALL_TIMEOUT_RST;
            cfg_reg.churn_threshold   <= psw_pkg::CHURN_THRESH_RST;
            cfg_reg.cooldown_ms       <= psw_pkg::COOLDOWN_RST;
            cfg_reg.delay_frames      <= psw_pkg::DELAY_RST;
            cfg_reg.prediction_frames <= psw_pkg::PREDICT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                psw_pkg::CFG_STALL_TIMEOUT: cfg_reg.stall_timeout_ms  <= cfg_wdata;
                psw_pkg::CFG_CHURN_THRESH:  cfg_reg.churn_threshold   <= cfg_wdata;
                psw_pkg::CFG_COOLDOWN:      cfg_reg.cooldown_ms       <= cfg_wdata;
                psw_pkg::CFG_DELAY:         cfg_reg.delay_frames      <= cfg_wdata[7:0];
                psw_pkg::CFG_PREDICT:       cfg_reg.prediction_frames <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/psw_core.sv =====
// baseline state and combinational stall decision
module psw_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  psw_pkg::in_item_t     item,
    input  psw_pkg::cfg_t         cfg,
    output psw_pkg::res_t         res,
    output psw_pkg::core_status_t status
);

    logic                 base_valid_reg, base_valid_next;
    logic                 cool_armed_reg, cool_armed_next;
    logic [31:0]          base_epoch_reg, base_epoch_next;
    psw_pkg::frame_t      base_lf_reg, base_lf_next;
    psw_pkg::frame_t      base_cf_reg, base_cf_next;
    logic [31:0]          base_stop_reg, base_stop_next;
    logic [31:0]          base_rb_reg, base_rb_next;
    logic [31:0]          last_prog_reg, last_prog_next;
    logic [31:0]          cool_until_reg, cool_until_next;

    logic                          ineligible, rearm, host_ok, in_cooldown;
    logic                          below_time, fire_req, fire, take;
    logic [psw_pkg::TOL_W-1:0]     tol_sum, tol;
    psw_pkg::frame_t               cur_lag, conf_lag;
    logic [31:0]                   cool_diff, stalled, sd, rd, churn;

    always_comb
    begin
        ineligible = !item.session_ok || !item.resync_idle || (item.remote_peers == 8'd0);
        rearm = !base_valid_reg || (base_epoch_reg != item.epoch)
              || (item.local_frame > base_lf_reg)
              || (item.confirmed_frame > base_cf_reg)
              || ((item.confirmed_frame >= item.local_frame)
                  && (item.remote_confirmed_frame >= item.confirmed_frame));

        tol_sum = psw_pkg::TOL_W'(cfg.delay_frames) + psw_pkg::TOL_W'(cfg.prediction_frames)
                + psw_pkg::TOLERANCE_PAD;
        tol = (tol_sum < psw_pkg::MIN_TOLERANCE) ? psw_pkg::MIN_TOLERANCE : tol_sum;
        cur_lag = (item.local_frame > item.remote_current_frame)
                ? item.local_frame - item.remote_current_frame : '0;
        conf_lag = (item.confirmed_frame > item.remote_confirmed_frame)
                 ? item.confirmed_frame - item.remote_confirmed_frame : '0;
        host_ok = item.is_host && (cur_lag <= psw_pkg::FRAME_W'(tol))
                && (conf_lag <= psw_pkg::FRAME_W'(tol));

        // wrap-safe: deadline still ahead when the signed difference is negative
        cool_diff   = item.now_ms - cool_until_reg;
        in_cooldown = cool_armed_reg && cool_diff[31];

        stalled    = item.now_ms - last_prog_reg;
        sd         = item.stop_count - base_stop_reg;
        rd         = item.rollback_count - base_rb_reg;
        churn      = (sd > rd) ? sd : rd;
        below_time = stalled[31] || (stalled < 32'(cfg.stall_timeout_ms));
        fire_req   = !(below_time && (churn < 32'(cfg.churn_threshold)));

        fire = !ineligible && !rearm && !host_ok && !in_cooldown && fire_req;
        take = !ineligible && (rearm || host_ok || fire);

        base_valid_next = base_valid_reg;
        cool_armed_next = cool_armed_reg;
        base_epoch_next = base_epoch_reg;
        base_lf_next    = base_lf_reg;
        base_cf_next    = base_cf_reg;
        base_stop_next  = base_stop_reg;
        base_rb_next    = base_rb_reg;
        last_prog_next  = last_prog_reg;
        cool_until_next = cool_until_reg;

        if (step)
        begin
            if (ineligible)
            begin
                base_valid_next = 1'b0;
                cool_armed_next = 1'b0;
            end
            else
            begin
                // outside a rearm or host pass, an elapsed cooldown is dropped so a clock wrap cannot revive it
                if (!rearm && !host_ok && cool_armed_reg && !cool_diff[31])
                    cool_armed_next = 1'b0;
                if (take)
                begin
                    base_valid_next = 1'b1;
                    base_epoch_next = item.epoch;
                    base_lf_next    = item.local_frame;
                    base_cf_next    = item.confirmed_frame;
                    base_stop_next  = item.stop_count;
                    base_rb_next    = item.rollback_count;
                    last_prog_next  = item.now_ms;
                end
                if (fire)
                begin
                    cool_armed_next = 1'b1;
                    cool_until_next = item.now_ms + 32'(cfg.cooldown_ms);
                end
            end
        end

        res.request_resync = fire;
        res.stalled_ms     = fire ? stalled : '0;
        res.stop_delta     = fire ? sd : '0;
        res.rollback_delta = fire ? rd : '0;

        status.fire           = step && fire;
        status.cool_armed     = cool_armed_reg;
        status.baseline_valid = base_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_valid_reg <= 1'b0;
            cool_armed_reg <= 1'b0;
        end
        else
        begin
            base_valid_reg <= base_valid_next;
            cool_armed_reg <= cool_armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_epoch_reg <= base_epoch_next;
        base_lf_reg    <= base_lf_next;
        base_cf_reg    <= base_cf_next;
        base_stop_reg  <= base_stop_next;
        base_rb_reg    <= base_rb_next;
        last_prog_reg  <= last_prog_next;
        cool_until_reg <= cool_until_next;
    end

endmodule
